@@ hdl/icsp_pkg.sv @@
// Shared types, constants and helpers for the image container section parser.
// No dependencies; the parser RTL modules refer to this package by scoped names.
package icsp_pkg;

    localparam int unsigned COUNT_BITS_DEF = 32;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [7:0] SEC_DIMS  = 8'h05;
    localparam logic [7:0] SEC_MULTI = 8'h0D;

    // Signature bytes in arrival order: element 0 comes first.
    localparam logic [3:0][7:0] SIG_BYTES = {8'h70, 8'h61, 8'h48, 8'h88};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [31:0] frame_offset;
        logic [31:0] frame_length;
    } t_result;

    // Top-level frame section types.
    function automatic logic is_top_level(input logic [7:0] t);
        logic lo_ok;
        logic hi_ok;
        lo_ok = t[3:0] inside {4'hB, 4'hE, 4'hF, 4'h1};
        hi_ok = t[7:4] inside {4'hA, 4'hB, 4'hC};
        return (t == SEC_MULTI) || (lo_ok && hi_ok);
    endfunction

endpackage

@@ hdl/icsp_intf.sv @@
// Valid/ready channel interfaces for the section parser's input bytes and results.
// Depends on nothing; payload fields are named after the block's item fields.
interface icsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [31:0] frame_offset;
    logic [31:0] frame_length;

    modport source (output valid, output status, output image_width, output image_height,
                    output frame_offset, output frame_length, input ready);
    modport sink   (input valid, input status, input image_width, input image_height,
                    input frame_offset, input frame_length, output ready);
endinterface

@@ hdl/icsp_in_reg.sv @@
// Input register of the section parser: holds one byte beat until the core takes it.
// Depends on icsp_pkg.
module icsp_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  icsp_pkg::t_beat      i_beat,
    input  logic                 i_take,
    output logic                 o_valid,
    output icsp_pkg::t_beat      o_beat
);
    logic            r_vld;
    icsp_pkg::t_beat r_beat;

    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end
endmodule

@@ hdl/icsp_core.sv @@
// Parse core: signature check, section header decode, dimensions capture, frame tracking.
// Depends on icsp_pkg. Updates its state on every taken beat; flags a result on the last.
module icsp_core #(
    parameter int unsigned COUNT_BITS = icsp_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  icsp_pkg::t_beat   i_beat,
    output logic              o_fire,
    output icsp_pkg::t_result o_result
);
    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_DONE = 3'd3;
    localparam logic [2:0] PH_ERR  = 3'd4;

    logic [2:0]            r_phase,      n_phase;
    logic [COUNT_BITS-1:0] r_pos,        n_pos;
    logic                  r_sig_err,    n_sig_err;
    logic [3:0]            r_hcnt,       n_hcnt;
    logic [23:0]           r_len3,       n_len3;
    logic [23:0]           r_len32_lo,   n_len32_lo;
    logic [7:0]            r_cur_type,   n_cur_type;
    logic [31:0]           r_remain,     n_remain;
    logic [7:0][7:0]       r_dims,       n_dims;
    logic                  r_have_dims,  n_have_dims;
    logic                  r_have_frame, n_have_frame;
    logic [31:0]           r_fstart,     n_fstart;
    logic [31:0]           r_fsize,      n_fsize;

    logic [7:0]  byte_in;
    logic [2:0]  hdr_idx;
    logic        hd4;
    logic        hd8;
    logic [7:0]  hd_type;
    logic [31:0] hd_body;
    logic [31:0] hd_hlen;
    logic        short_buf;
    logic [31:0] rem_dec;

    assign byte_in   = i_beat.data_byte;
    assign hdr_idx   = r_hcnt[2:0];
    assign hd4       = (hdr_idx == 3'd3) && (r_len3 != 24'd0);
    assign hd8       = (hdr_idx == 3'd7);
    assign hd_type   = hd8 ? r_cur_type : byte_in;
    assign hd_body   = hd8 ? {byte_in, r_len32_lo} : {8'd0, r_len3};
    assign hd_hlen   = hd8 ? 32'd8 : 32'd4;
    assign short_buf = (r_phase == PH_SIG) && i_beat.last_byte
                       && (r_pos < COUNT_BITS'(3));
    assign rem_dec   = r_remain - 32'd1;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_sig_err    = r_sig_err;
        n_hcnt       = r_hcnt;
        n_len3       = r_len3;
        n_len32_lo   = r_len32_lo;
        n_cur_type   = r_cur_type;
        n_remain     = r_remain;
        n_dims       = r_dims;
        n_have_dims  = r_have_dims;
        n_have_frame = r_have_frame;
        n_fstart     = r_fstart;
        n_fsize      = r_fsize;

        if (!short_buf && (r_phase != PH_DONE) && (r_phase != PH_ERR)) begin
            if (r_pos == '1) begin
                n_phase = PH_ERR;
            end else begin
                n_pos = r_pos + COUNT_BITS'(1);
                case (r_phase)
                    PH_SIG: begin
                        if (byte_in != icsp_pkg::SIG_BYTES[r_pos[1:0]]) begin
                            n_sig_err = 1'b1;
                        end
                        if (r_pos[1:0] == 2'd3) begin
                            n_phase = n_sig_err ? PH_ERR : PH_HDR;
                        end
                    end
                    PH_HDR: begin
                        n_hcnt = r_hcnt + 4'd1;
                        case (hdr_idx)
                            3'd0:    n_len3[7:0]       = byte_in;
                            3'd1:    n_len3[15:8]      = byte_in;
                            3'd2:    n_len3[23:16]     = byte_in;
                            3'd3:    n_cur_type        = byte_in;
                            3'd4:    n_len32_lo[7:0]   = byte_in;
                            3'd5:    n_len32_lo[15:8]  = byte_in;
                            3'd6:    n_len32_lo[23:16] = byte_in;
                            default: n_cur_type        = r_cur_type;
                        endcase
                        if (hd4 || hd8) begin
                            // Header complete: latch type and body length.
                            n_cur_type = hd_type;
                            n_remain   = hd_body;
                            n_hcnt     = 4'd0;
                            if (hd_type == icsp_pkg::SEC_DIMS) begin
                                n_have_dims = 1'b1;
                                n_dims      = '0;
                            end else if (icsp_pkg::is_top_level(hd_type)) begin
                                n_have_frame = 1'b1;
                                n_fstart     = 32'(r_pos) + 32'd1 - hd_hlen;
                                n_fsize      = hd_hlen + hd_body;
                            end
                            if ((hd_type == icsp_pkg::SEC_DIMS) && (hd_body < 32'd8)) begin
                                n_phase = PH_ERR;
                            end else if (hd_body == 32'd0) begin
                                n_phase = (n_have_dims && n_have_frame) ? PH_DONE : PH_HDR;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        if ((r_cur_type == icsp_pkg::SEC_DIMS) && !r_hcnt[3]) begin
                            n_dims[hdr_idx] = byte_in;
                            n_hcnt          = r_hcnt + 4'd1;
                        end
                        n_remain = rem_dec;
                        if (rem_dec == 32'd0) begin
                            n_hcnt  = 4'd0;
                            n_phase = (r_have_dims && r_have_frame) ? PH_DONE : PH_HDR;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    assign o_fire = i_take && i_beat.last_byte;

    always_comb begin
        o_result = '0;
        if (short_buf) begin
            o_result.status = icsp_pkg::ST_SHORT;
        end else if (n_phase == PH_DONE) begin
            o_result.status       = icsp_pkg::ST_OK;
            o_result.image_width  = n_dims[3:0];
            o_result.image_height = n_dims[7:4];
            o_result.frame_offset = n_fstart;
            o_result.frame_length = n_fsize;
        end else begin
            o_result.status = icsp_pkg::ST_BAD;
        end
    end

    // Control state: back to the signature phase after reset and after each last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIG;
            r_pos        <= '0;
            r_sig_err    <= 1'b0;
            r_hcnt       <= 4'd0;
            r_have_dims  <= 1'b0;
            r_have_frame <= 1'b0;
        end else if (i_take) begin
            if (i_beat.last_byte) begin
                r_phase      <= PH_SIG;
                r_pos        <= '0;
                r_sig_err    <= 1'b0;
                r_hcnt       <= 4'd0;
                r_have_dims  <= 1'b0;
                r_have_frame <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_pos        <= n_pos;
                r_sig_err    <= n_sig_err;
                r_hcnt       <= n_hcnt;
                r_have_dims  <= n_have_dims;
                r_have_frame <= n_have_frame;
            end
        end
    end

    // Payload state: only read once the matching control state says it is valid.
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_len3     <= n_len3;
            r_len32_lo <= n_len32_lo;
            r_cur_type <= n_cur_type;
            r_remain   <= n_remain;
            r_dims     <= n_dims;
            r_fstart   <= n_fstart;
            r_fsize    <= n_fsize;
        end
    end
endmodule

@@ hdl/icsp_out_reg.sv @@
// Result register of the section parser: holds one result beat until the sink takes it.
// Depends on icsp_pkg.
module icsp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  icsp_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output icsp_pkg::t_result o_result
);
    logic              r_vld;
    icsp_pkg::t_result r_result;

    assign o_can_load = !r_vld || i_ready;
    assign o_valid    = r_vld;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end
endmodule

@@ hdl/image_container_section_parser_top.sv @@
// Image container section parser. Feed the buffer one byte per beat on i_item, with
// last_byte set on the final byte; exactly one result beat per buffer comes out on
// o_result, carrying status (ok, buffer shorter than the signature, or bad image) and,
// when ok, the 32-bit width and height from the dimensions section and the offset and
// total length of the last top-level frame section. Fields other than status read zero
// unless status is ok. The block takes one byte every clock cycle with no gaps between
// buffers; a byte is held in the input register and its result, if any, is registered
// in the result register. A byte stalls only while a finished result still sits unread
// and the waiting byte is a last byte. After each last byte the parser is back in its
// initial state, ready for the next buffer. COUNT_BITS sets the byte-position counter;
// a buffer that is still being parsed when that counter is full is reported as bad.
// Depends on icsp_pkg, icsp_intf, icsp_in_reg, icsp_core and icsp_out_reg.
module image_container_section_parser_top #(
    parameter int unsigned COUNT_BITS = icsp_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    icsp_in_if.sink    i_item,
    icsp_out_if.source o_result
);
    icsp_pkg::t_beat   in_beat;
    icsp_pkg::t_beat   held_beat;
    icsp_pkg::t_result core_result;
    icsp_pkg::t_result out_result;
    logic              held_valid;
    logic              take;
    logic              fire;
    logic              out_can_load;

    // Pack the incoming beat.
    assign in_beat.data_byte = i_item.data_byte;
    assign in_beat.last_byte = i_item.last_byte;

    // Advance a held byte unless it would produce a result while the result
    // register is still occupied and not being drained.
    assign take = held_valid && (!held_beat.last_byte || out_can_load);

    icsp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_beat  (in_beat),
        .i_take  (take),
        .o_valid (held_valid),
        .o_beat  (held_beat)
    );

    icsp_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_beat   (held_beat),
        .o_fire   (fire),
        .o_result (core_result)
    );

    icsp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (core_result),
        .o_can_load (out_can_load),
        .o_valid    (o_result.valid),
        .i_ready    (o_result.ready),
        .o_result   (out_result)
    );

    // Unpack the result beat onto the output channel.
    assign o_result.status       = out_result.status;
    assign o_result.image_width  = out_result.image_width;
    assign o_result.image_height = out_result.image_height;
    assign o_result.frame_offset = out_result.frame_offset;
    assign o_result.frame_length = out_result.frame_length;
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for image_container_section_parser_top: directed byte table,
// then random image buffers under several idle/stall mixes and a long result hold-off,
// all checked by a local predictor. Depends on icsp_pkg, icsp_intf and the parser RTL.
module tb_top;
    import icsp_pkg::*;

    // Run the block with a 16-bit position counter.
    localparam int unsigned CNT_BITS     = 16;
    localparam logic [63:0] POS_CAP      = (64'd1 << CNT_BITS) - 64'd1;
    localparam int unsigned PHASE_BYTES  = 480;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_IDLE[4]  = '{0, 88, 0, 19};
    localparam int PHASE_STALL[4] = '{0, 0, 88, 19};

    // Section type that is neither dimensions nor a top-level frame.
    localparam logic [7:0] SEC_FILLER = 8'h42;
    localparam logic [3:0] FRAME_HI[3] = '{4'hA, 4'hB, 4'hC};
    localparam logic [3:0] FRAME_LO[4] = '{4'hB, 4'hE, 4'hF, 4'h1};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;  // result below is the expected one, not the predictor's
        t_result    res;
    } row_t;

    localparam t_result RES_NONE  = '0;
    localparam t_result RES_SHORT = '{ST_SHORT, 32'd0, 32'd0, 32'd0, 32'd0};
    // Dimensions FFFFFFFF x 0, then an 8-byte frame header with zero body at offset 16.
    localparam t_result RES_GOOD  = '{ST_OK, 32'hFFFF_FFFF, 32'd0, 32'd16, 32'd8};

    localparam row_t DIRECTED_ROWS[28] = '{
        // one byte only: shorter than the signature
        '{8'h00, 1'b1, 1'b1, RES_SHORT},
        // signature prefix, still short
        '{8'h88, 1'b0, 1'b0, RES_NONE},
        '{8'h48, 1'b0, 1'b0, RES_NONE},
        '{8'h61, 1'b1, 1'b1, RES_SHORT},
        // minimal good image: signature, dimensions, empty extended frame header
        '{8'h88, 1'b0, 1'b0, RES_NONE},
        '{8'h48, 1'b0, 1'b0, RES_NONE},
        '{8'h61, 1'b0, 1'b0, RES_NONE},
        '{8'h70, 1'b0, 1'b0, RES_NONE},
        '{8'h08, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{SEC_DIMS, 1'b0, 1'b0, RES_NONE},
        '{8'hFF, 1'b0, 1'b0, RES_NONE},
        '{8'hFF, 1'b0, 1'b0, RES_NONE},
        '{8'hFF, 1'b0, 1'b0, RES_NONE},
        '{8'hFF, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{SEC_MULTI, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b0, 1'b0, RES_NONE},
        '{8'h00, 1'b1, 1'b1, RES_GOOD}
    };

    typedef enum logic [2:0] {
        PS_SIGNATURE, PS_HEADER, PS_BODY, PS_DONE, PS_BAD
    } parse_state_e;

    typedef enum int {SK_DIMS, SK_FRAME, SK_OTHER} section_kind_e;

    logic clk = 1'b0;
    logic rst_n;

    icsp_in_if  byte_ch ();
    icsp_out_if result_ch ();

    image_container_section_parser_top #(.COUNT_BITS(CNT_BITS)) DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (byte_ch),
        .o_result (result_ch)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser predictor: mirrors the block's parse state byte by byte.
    // ------------------------------------------------------------------
    parse_state_e ps;
    logic [63:0]  p_pos;
    logic [63:0]  p_hdr;
    int unsigned  p_hdr_cnt;
    logic [63:0]  p_remain;
    logic [7:0]   p_type;
    logic [63:0]  p_dims;
    logic         p_have_dims;
    logic         p_have_frame;
    logic [63:0]  p_frame_at;
    logic [63:0]  p_frame_len;
    logic [1:0]   p_err;

    t_result      pending_results[$];
    logic [7:0]   img_q[$];
    int unsigned  bytes_sent = 0;
    int unsigned  cycle_count = 0;
    int           errors = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    bit           hold_req = 1'b0;

    function automatic void parser_clear();
        ps           = PS_SIGNATURE;
        p_pos        = '0;
        p_hdr        = '0;
        p_hdr_cnt    = 0;
        p_remain     = '0;
        p_type       = '0;
        p_dims       = '0;
        p_have_dims  = 1'b0;
        p_have_frame = 1'b0;
        p_frame_at   = '0;
        p_frame_len  = '0;
        p_err        = ST_OK;
    endfunction

    function automatic logic frame_section(input logic [7:0] t);
        logic lo_hit;
        logic hi_hit;
        lo_hit = (t[3:0] == 4'hB) || (t[3:0] == 4'hE) || (t[3:0] == 4'hF) || (t[3:0] == 4'h1);
        hi_hit = (t[7:4] == 4'hA) || (t[7:4] == 4'hB) || (t[7:4] == 4'hC);
        return (t == SEC_MULTI) || (lo_hit && hi_hit);
    endfunction

    function automatic void mark_bad();
        p_err = ST_BAD;
        ps    = PS_BAD;
    endfunction

    function automatic void close_section();
        p_hdr_cnt = 0;
        p_hdr     = '0;
        ps        = (p_have_dims && p_have_frame) ? PS_DONE : PS_HEADER;
    endfunction

    // Header complete on the byte at hand; body_len is the exact length, no wrap.
    function automatic void open_section(input logic [63:0] hdr_len, input logic [63:0] body_len);
        p_type    = p_hdr[31:24];
        p_remain  = body_len;
        p_hdr_cnt = 0;
        if (p_type == SEC_DIMS) begin
            if (body_len < 64'd8) begin
                mark_bad();
                return;
            end
            p_have_dims = 1'b1;
            p_dims      = '0;
        end else if (frame_section(p_type)) begin
            p_have_frame = 1'b1;
            p_frame_at   = p_pos - hdr_len;
            p_frame_len  = hdr_len + body_len;
        end
        if (body_len == 64'd0)
            close_section();
        else
            ps = PS_BODY;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int unsigned slot;
        if (ps == PS_DONE || ps == PS_BAD)
            return;
        if (p_pos >= POS_CAP) begin
            mark_bad();
            return;
        end
        p_pos++;
        case (ps)
            PS_SIGNATURE: begin
                if (b != SIG_BYTES[2'(p_pos - 64'd1)])
                    p_err = ST_BAD;
                if (p_pos >= 64'd4)
                    ps = (p_err != ST_OK) ? PS_BAD : PS_HEADER;
            end
            PS_HEADER: begin
                slot      = p_hdr_cnt & 7;
                p_hdr     = p_hdr | (64'(b) << (slot * 8));
                p_hdr_cnt = slot + 1;
                if (p_hdr_cnt == 4) begin
                    if (p_hdr[23:0] != 24'd0)
                        open_section(64'd4, 64'(p_hdr[23:0]));
                end else if (p_hdr_cnt == 8) begin
                    open_section(64'd8, 64'(p_hdr[63:32]));
                end
            end
            default: begin
                if (p_type == SEC_DIMS && p_hdr_cnt < 8) begin
                    p_dims = p_dims | (64'(b) << (p_hdr_cnt * 8));
                    p_hdr_cnt++;
                end
                p_remain--;
                if (p_remain == 64'd0)
                    close_section();
            end
        endcase
    endfunction

    // Returns 1 when this byte closes the buffer and yields a result.
    function automatic bit parse_step(input logic [7:0] b, input logic last,
                                      output t_result res);
        logic [1:0] status;
        res = '0;
        if (ps == PS_SIGNATURE && last && p_pos + 64'd1 < 64'd4) begin
            status = ST_SHORT;
        end else begin
            parse_byte(b);
            if (!last)
                return 1'b0;
            status = (ps == PS_DONE) ? ST_OK : ST_BAD;
        end
        res.status = status;
        if (status == ST_OK) begin
            res.image_width  = p_dims[31:0];
            res.image_height = p_dims[63:32];
            res.frame_offset = p_frame_at[31:0];
            res.frame_length = p_frame_len[31:0];
        end
        parser_clear();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Image buffer generation
    // ------------------------------------------------------------------
    function automatic void push_signature();
        for (int i = 0; i < 4; i++)
            img_q.push_back(SIG_BYTES[i]);
    endfunction

    // Short header carries a 3-byte length; wide one has zero there and a 32-bit length after.
    function automatic void push_header(input logic [7:0] t, input logic [31:0] len,
                                        input bit wide);
        if (wide) begin
            img_q.push_back(8'h00);
            img_q.push_back(8'h00);
            img_q.push_back(8'h00);
            img_q.push_back(t);
            for (int i = 0; i < 4; i++)
                img_q.push_back(len[8*i +: 8]);
        end else begin
            img_q.push_back(len[7:0]);
            img_q.push_back(len[15:8]);
            img_q.push_back(len[23:16]);
            img_q.push_back(t);
        end
    endfunction

    function automatic void add_section(input section_kind_e kind);
        logic [7:0]  t;
        logic [31:0] len;
        int unsigned nbody;
        int unsigned fill;
        bit          huge;
        bit          wide;
        huge = ($urandom_range(99) < 3);
        case (kind)
            SK_DIMS: begin
                t   = SEC_DIMS;
                len = ($urandom_range(99) < 90) ? $urandom_range(8, 12) : $urandom_range(0, 7);
            end
            SK_FRAME: begin
                if ($urandom_range(1) == 0)
                    t = SEC_MULTI;
                else
                    t = {FRAME_HI[$urandom_range(2)], FRAME_LO[$urandom_range(3)]};
                len = $urandom_range(0, 6);
            end
            default: begin
                t = 8'($urandom_range(255));
                if (t == SEC_DIMS)
                    t = SEC_FILLER;
                len = $urandom_range(0, 8);
            end
        endcase
        // A huge section cannot arrive whole, so the buffer ends inside its body.
        if (huge)
            len = ($urandom_range(1) == 0) ? 32'h00FF_FFFF : 32'hFFFF_FFFF;
        wide = (len == 0) || (len > 32'h00FF_FFFF) || ($urandom_range(3) == 0);
        push_header(t, len, wide);
        nbody = huge ? $urandom_range(0, 5) : len;
        fill  = $urandom_range(9);
        for (int i = 0; i < nbody; i++) begin
            case (fill)
                0:       img_q.push_back(8'h00);
                1:       img_q.push_back(8'hFF);
                default: img_q.push_back(8'($urandom));
            endcase
        end
    endfunction

    function automatic void build_image();
        section_kind_e kinds[$];
        section_kind_e tmp;
        int unsigned   n;
        int unsigned   j;
        int unsigned   keep;
        bit            full;
        img_q.delete();
        if ($urandom_range(99) < 8) begin
            // noise: random bytes, mostly failing the signature or too short
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                img_q.push_back(8'($urandom));
            return;
        end
        push_signature();
        if ($urandom_range(99) < 6)
            img_q[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        full = ($urandom_range(99) < 75);
        if (full) begin
            kinds.push_back(SK_DIMS);
            kinds.push_back(SK_FRAME);
        end
        n = $urandom_range(0, full ? 2 : 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) == 0)
                kinds.push_back(SK_FRAME);
            else if ($urandom_range(4) == 0)
                kinds.push_back(SK_DIMS);
            else
                kinds.push_back(SK_OTHER);
        end
        for (int i = kinds.size() - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = kinds[i];
            kinds[i] = kinds[j];
            kinds[j] = tmp;
        end
        foreach (kinds[i])
            add_section(kinds[i]);
        // trailing bytes after parsing stops are ignored by the block
        if ($urandom_range(1) == 0) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                img_q.push_back(8'($urandom));
        end
        // cut some buffers anywhere: inside headers, bodies or the signature
        if ($urandom_range(99) < 10) begin
            keep = $urandom_range(1, img_q.size());
            while (img_q.size() > keep)
                void'(img_q.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: change inputs at the falling edge, take acceptance at the rising one.
    // Enter and leave on a falling edge.
    // ------------------------------------------------------------------
    task automatic send_beat(input row_t row);
        t_result pred;
        bit      emits;
        while ($urandom_range(99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= row.data;
        byte_ch.last_byte <= row.last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        // Beat accepted: advance the predictor and queue what it causes.
        emits = parse_step(row.data, row.last, pred);
        if (row.pinned)
            pending_results.push_back(row.res);
        else if (emits)
            pending_results.push_back(pred);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_image();
        row_t row;
        for (int i = 0; i < img_q.size(); i++) begin
            row.data   = img_q[i];
            row.last   = (i == img_q.size() - 1);
            row.pinned = 1'b0;
            row.res    = RES_NONE;
            send_beat(row);
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : result_sink
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    result_ch.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare every accepted result beat with the oldest pending one.
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got status %0d",
                         $time, result_ch.status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(result_ch.status));
                check_field("image_width", want.image_width, result_ch.image_width);
                check_field("image_height", want.image_height, result_ch.image_height);
                check_field("frame_offset", want.frame_offset, result_ch.frame_offset);
                check_field("frame_length", want.frame_length, result_ch.frame_length);
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned stop_at;
        int unsigned n;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        rst_n             = 1'b0;
        parser_clear();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: short buffers and a minimal good image with extreme dimensions.
        foreach (DIRECTED_ROWS[i])
            send_beat(DIRECTED_ROWS[i]);

        // Random images under each idle/stall mix.
        for (int p = 0; p < 4; p++) begin
            idle_pct  = PHASE_IDLE[p];
            stall_pct = PHASE_STALL[p];
            stop_at   = bytes_sent + PHASE_BYTES;
            while (bytes_sent < stop_at) begin
                build_image();
                send_image();
            end
        end

        // Hold the result side off while short buffers keep coming, so the input stalls.
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        for (int k = 0; k < 40; k++) begin
            img_q.delete();
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                img_q.push_back(8'($urandom));
            send_image();
        end

        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hdl/icsp_pkg.sv
hdl/icsp_intf.sv
hdl/icsp_in_reg.sv
hdl/icsp_core.sv
hdl/icsp_out_reg.sv
hdl/image_container_section_parser_top.sv
verif/tb_top.sv
